/* hw/rtl/ptd_pkg.sv */
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared constants and types for the trial-division primality tester.
// ----------------------------------------------------------------------------
package ptd_pkg;

  // width of the candidate port
  localparam int CandW = 32;
  // width of the tested value (low bits of the candidate, sign at the top)
  localparam int ValW = 32;
  // divisor width: covers sqrt(2^(ValW-1)) plus the wheel step
  localparam int DivW = ValW / 2 + 2;
  // bit counter width for one serial division
  localparam int CntW = $clog2(ValW);

  localparam logic [DivW-1:0] FirstDiv = DivW'(3);
  localparam logic [DivW-1:0] WheelBase = DivW'(5);
  localparam logic [DivW-1:0] WheelStep = DivW'(6);
  localparam logic [DivW-1:0] PairOffset = DivW'(2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_BY3,
    PH_BYD,
    PH_BYD2
  } phase_t;

endpackage

/* hw/rtl/prime_test_trial_division.sv */
// ----------------------------------------------------------------------------
// prime_test_trial_division
// Primality test of a signed integer by trial division over the 6k+/-1 wheel.
//
// Input channel (in_valid / in_stall / candidate) takes one value per
// transaction; the output channel (out_valid / out_stall / is_prime) returns
// exactly one result per input transaction, in order.
// Negative values, 0 and 1 give 0; 2 and 3 give 1; even values give 0. These
// skip the divider. Other values go through a bit-serial restoring divider
// that retires one quotient bit per cycle, one full division per trial divisor: first
// 3, then d and d+2 for d = 5, 11, 17, ... while d <= n/d. One value is in
// work at a time; in_stall is high from acceptance until the result has been
// moved into the output register. The output register holds one finished
// result, so the next value is taken while that result waits. While
// out_stall is high the result and out_valid hold. Synchronous reset returns
// to idle with no result pending.
// ----------------------------------------------------------------------------
module prime_test_trial_division (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [ptd_pkg::CandW-1:0] candidate,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           is_prime
);

  localparam int VW = ptd_pkg::ValW;
  localparam int DW = ptd_pkg::DivW;
  localparam int CW = ptd_pkg::CntW;

  ptd_pkg::state_t state, state_next;
  ptd_pkg::phase_t phase, phase_next;

  logic [VW-1:0] held_value, held_value_next;
  logic [VW-1:0] dq, dq_next;
  logic [DW-1:0] rem, rem_next;
  logic [DW-1:0] divisor, divisor_next;
  logic [DW-1:0] trial_divisor, trial_divisor_next;
  logic [CW-1:0] count, count_next;
  logic          result, result_next;
  logic          load_out;

  logic [VW-1:0] raw;
  logic [DW:0]   rem_shift;
  logic          fits;
  logic [DW-1:0] rem_step;
  logic [VW-1:0] q_step;
  logic          accept;

  assign raw = candidate[VW-1:0];
  assign in_stall = (state != ptd_pkg::ST_IDLE);
  assign accept = in_valid && !in_stall;

  assign rem_shift = {rem, dq[VW-1]};
  assign fits = (rem_shift >= {1'b0, divisor});
  assign rem_step = fits ? DW'(rem_shift - {1'b0, divisor}) : rem_shift[DW-1:0];
  assign q_step = {dq[VW-2:0], fits};

  always_comb begin
    state_next = state;
    phase_next = phase;
    held_value_next = held_value;
    dq_next = dq;
    rem_next = rem;
    divisor_next = divisor;
    trial_divisor_next = trial_divisor;
    count_next = count;
    result_next = result;
    load_out = 1'b0;
    case (state)
      ptd_pkg::ST_IDLE: begin
        if (accept) begin
          held_value_next = raw;
          trial_divisor_next = '0;
          dq_next = raw;
          rem_next = '0;
          count_next = CW'(VW - 1);
          divisor_next = ptd_pkg::FirstDiv;
          phase_next = ptd_pkg::PH_BY3;
          if (raw[VW-1] || raw[VW-2:1] == '0) begin
            result_next = 1'b0;
            state_next = ptd_pkg::ST_DONE;
          end else if (raw[VW-2:2] == '0) begin
            result_next = 1'b1;
            state_next = ptd_pkg::ST_DONE;
          end else if (!raw[0]) begin
            result_next = 1'b0;
            state_next = ptd_pkg::ST_DONE;
          end else begin
            state_next = ptd_pkg::ST_DIV;
          end
        end
      end
      ptd_pkg::ST_DIV: begin
        dq_next = q_step;
        rem_next = rem_step;
        count_next = count - CW'(1);
        if (count == '0) begin
          dq_next = held_value;
          rem_next = '0;
          count_next = CW'(VW - 1);
          case (phase)
            ptd_pkg::PH_BY3: begin
              if (rem_step == '0) begin
                result_next = 1'b0;
                state_next = ptd_pkg::ST_DONE;
              end else begin
                trial_divisor_next = ptd_pkg::WheelBase;
                divisor_next = ptd_pkg::WheelBase;
                phase_next = ptd_pkg::PH_BYD;
              end
            end
            ptd_pkg::PH_BYD: begin
              if (q_step < VW'(trial_divisor)) begin
                result_next = 1'b1;
                state_next = ptd_pkg::ST_DONE;
              end else if (rem_step == '0) begin
                result_next = 1'b0;
                state_next = ptd_pkg::ST_DONE;
              end else begin
                divisor_next = trial_divisor + ptd_pkg::PairOffset;
                phase_next = ptd_pkg::PH_BYD2;
              end
            end
            ptd_pkg::PH_BYD2: begin
              if (rem_step == '0) begin
                result_next = 1'b0;
                state_next = ptd_pkg::ST_DONE;
              end else begin
                trial_divisor_next = trial_divisor + ptd_pkg::WheelStep;
                divisor_next = trial_divisor + ptd_pkg::WheelStep;
                phase_next = ptd_pkg::PH_BYD;
              end
            end
            default: begin
              state_next = ptd_pkg::ST_IDLE;
            end
          endcase
        end
      end
      ptd_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out = 1'b1;
          state_next = ptd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ptd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptd_pkg::ST_IDLE;
      phase <= ptd_pkg::PH_BY3;
      held_value <= '0;
      trial_divisor <= '0;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      held_value <= held_value_next;
      trial_divisor <= trial_divisor_next;
      count <= count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dq <= dq_next;
    rem <= rem_next;
    divisor <= divisor_next;
    result <= result_next;
    if (load_out) begin
      is_prime <= result;
    end
  end

  // partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == ptd_pkg::ST_DIV |-> rem < divisor)
    else $error("partial remainder not below divisor");

  // every trial divisor is odd
  a_div_odd: assert property (@(posedge clk) disable iff (rst)
    state == ptd_pkg::ST_DIV |-> divisor[0])
    else $error("even trial divisor");

  // divisor matches the phase: 3, the wheel base d, or d + 2
  a_div_phase: assert property (@(posedge clk) disable iff (rst)
    state == ptd_pkg::ST_DIV |->
      (phase == ptd_pkg::PH_BY3 && divisor == ptd_pkg::FirstDiv) ||
      (phase == ptd_pkg::PH_BYD && divisor == trial_divisor) ||
      (phase == ptd_pkg::PH_BYD2 && divisor == trial_divisor + ptd_pkg::PairOffset))
    else $error("divisor out of step with wheel");

  // a new result only appears after a finished test
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ptd_pkg::ST_DONE)
    else $error("result without finished test");

endmodule

/* bench/prime_test_trial_division_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_test_trial_division_tb
// Self-checking bench for the trial-division primality tester: directed edge
// values, a long output hold-off, a random mix of small, medium, negative and
// large composite candidates with idle bursts, and a final idle-free stream.
// Each transaction result is checked in order against an in-bench predictor.
// ----------------------------------------------------------------------------
module prime_test_trial_division_tb;

  localparam int CandW = ptd_pkg::CandW;

  typedef struct packed {
    logic [CandW-1:0] value;
    logic             prime;
  } verdict_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [CandW-1:0] candidate = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    is_prime;

  verdict_t pending_verdicts[$];
  int       errors = 0;
  bit       idle_en = 1'b1;
  int       hold_requests = 0;
  int       holds_served = 0;
  int       hold_left = 0;
  int       burst_left = 0;

  prime_test_trial_division u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .candidate(candidate),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .is_prime(is_prime)
  );

  always #1 clk = ~clk;

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // 6k +/- 1 wheel, bound d <= n/d so nothing overflows
  function automatic logic primality_of(input logic signed [CandW-1:0] value);
    longint unsigned n;
    longint unsigned d;
    if (value <= 1) return 1'b0;
    n = 64'(value);
    if (n <= 3) return 1'b1;
    if (n % 2 == 0 || n % 3 == 0) return 1'b0;
    for (d = 5; d <= n / d; d += 6) begin
      if (n % d == 0 || n % (d + 2) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic offer_candidate(input logic signed [CandW-1:0] value);
    int       gap;
    verdict_t v;
    if (idle_en && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 10);
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    candidate <= value;
    do @(posedge clk); while (in_stall);
    v.value = value;
    v.prime = primality_of(value);
    pending_verdicts.push_back(v);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  // result checker and receiver stall generator
  always @(posedge clk) begin : result_check
    verdict_t due;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual is_prime=%0b",
                   $time, is_prime);
          errors++;
        end else begin
          due = pending_verdicts.pop_front();
          if (is_prime !== due.prime) begin
            $display("%0t: is_prime mismatch for %0d: expected %0b, actual %0b",
                     $time, $signed(due.value), due.prime, is_prime);
            errors++;
          end
        end
      end
      if (holds_served < hold_requests) begin
        holds_served++;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(1, 10) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_non_positive();
    offer_candidate(32'sh8000_0000);
    offer_candidate(-32'sd1);
    offer_candidate(32'sd0);
    offer_candidate(32'sd1);
  endtask

  // small primes, wheel squares and products on both sides of the pair
  task automatic test_small_wheel();
    offer_candidate(32'sd2);
    offer_candidate(32'sd3);
    offer_candidate(32'sd4);
    offer_candidate(32'sd5);
    offer_candidate(32'sd6);
    offer_candidate(32'sd7);
    offer_candidate(32'sd9);
    offer_candidate(32'sd25);
    offer_candidate(32'sd35);
    offer_candidate(32'sd49);
    offer_candidate(32'sd121);
    offer_candidate(32'sd143);
    offer_candidate(32'sd169);
    offer_candidate(32'sd10403);
  endtask

  task automatic test_range_top();
    offer_candidate(32'sd65521);
    offer_candidate(32'sd1018081);
    offer_candidate(32'sd1038361);
    offer_candidate(32'sd2147483646);
    offer_candidate(32'sd2147483645);
    offer_candidate(32'sd2147483647);
    wait_all_results();
  endtask

  // receiver holds off while quick transactions pile up behind the output
  task automatic test_output_hold();
    idle_en = 1'b0;
    hold_requests++;
    offer_candidate(32'sd8);
    offer_candidate(-32'sd77);
    offer_candidate(32'sd2);
    offer_candidate(32'sd100);
    offer_candidate(32'sd3);
    offer_candidate(32'sd0);
    wait_all_results();
    idle_en = 1'b1;
  endtask

  task automatic test_random_mix(input int count);
    int               pick;
    int unsigned      factor;
    logic [CandW-1:0] value;
    int unsigned      factors[6] = '{2, 3, 5, 7, 11, 13};
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        value = $urandom_range(0, 4095);
      end else if (pick < 60) begin
        value = $urandom_range(4096, 262143);
      end else if (pick < 75) begin
        value = {1'b1, 31'($urandom())};
      end else if (pick < 95) begin
        // large but with a small factor, so the divider exits early
        factor = factors[$urandom_range(0, 5)];
        value = $urandom_range(1, 32'h7FFF_FFFF / factor) * factor;
      end else begin
        value = CandW'(int'($urandom_range(0, 16)) - 8);
      end
      offer_candidate(value);
    end
  endtask

  task automatic test_steady_stream(input int count);
    idle_en = 1'b0;
    repeat (count) offer_candidate($urandom_range(0, 1023));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_non_positive();
    test_small_wheel();
    test_range_top();
    test_output_hold();
    test_random_mix(70);
    test_steady_stream(15);
    wait_all_results();
    repeat (40) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $display("%0t: %0d results missing: expected %0d more, actual 0",
               $time, pending_verdicts.size(), pending_verdicts.size());
      errors++;
    end
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/ptd_pkg.sv
hw/rtl/prime_test_trial_division.sv
bench/prime_test_trial_division_tb.sv
